// File: design/frame_slot_rotation_manager_defines.svh
// Assertion macros for the frame slot rotation manager.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef FRAME_SLOT_ROTATION_MANAGER_DEFINES_SVH
`define FRAME_SLOT_ROTATION_MANAGER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define FSRM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define FSRM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/fsrm_pkg.sv
// Shared types and constants of the frame slot rotation manager.
// No dependencies; imported by fsrm_regs, the top level and the testbench.
package fsrm_pkg;

  localparam int COUNT_W  = 4;
  localparam int STRIDE_W = 19;
  localparam int OFFSET_W = 22;
  localparam int SLOT_W   = 3;
  localparam int ACTION_W = 3;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [COUNT_W-1:0]  COUNT_RST  = 4'd1;
  localparam logic [STRIDE_W-1:0] STRIDE_RST = 19'd409600;

  // Slot counts that pick a special rotation.
  localparam int SINGLE_COUNT = 1;
  localparam int TRIPLE_COUNT = 3;

  // Register index, taken from paddr[2].
  localparam logic REG_SLOT_COUNT  = 1'b0;
  localparam logic REG_SLOT_STRIDE = 1'b1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TAKE_HEAD   = 3'd0,
    ACT_TAKE_TAIL   = 3'd1,
    ACT_RELEASE     = 3'd2,
    ACT_FLUSH       = 3'd3,
    ACT_RESET_SLOTS = 3'd4
  } action_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  slot_count;
    logic [STRIDE_W-1:0] slot_stride;
    logic                rebuild;     // slot_count written this cycle
  } cfg_t;

endpackage

// File: design/frame_slot_rotation_manager.sv
// Frame slot rotation manager: hands frame slots between a writer and a reader.
// Depends on fsrm_pkg, fsrm_regs and frame_slot_rotation_manager_defines.svh.
//
// Usage:
//   Requests enter on in_action / in_peek when start is high and busy is low.
//   busy stays low, so one request may be issued every cycle.
//   Each request yields exactly one result, shown for one cycle with
//   out_valid high: the request register loads at the accepting edge and
//   the slot decision is written into the result register at the next
//   one.
//   Throughput is one request per cycle; the state update of one request is
//   written at the same edge as its result, in time for the next request.
//   The receiver cannot stall; results are never held.
//   Configuration goes through the APB port: slot_count at 0x0, slot_stride
//   at 0x4. Writing slot_count rebuilds the rotation (head, tail and all
//   header-pending bits cleared). Write configuration only while idle.
//   Reset (rst_n low, synchronous) restores single-slot mode, the default
//   stride, head and tail at slot 0 and drops any request in flight.
`include "frame_slot_rotation_manager_defines.svh"

module frame_slot_rotation_manager #(
  parameter int MAX_SLOTS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [fsrm_pkg::ACTION_W-1:0]    in_action,
  input  logic                             in_peek,
  output logic                             out_valid,
  output logic                             out_granted,
  output logic [fsrm_pkg::SLOT_W-1:0]      out_slot,
  output logic [fsrm_pkg::OFFSET_W-1:0]    out_slot_offset,
  output logic                             out_clear_header,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fsrm_pkg::APB_AW-1:0]      paddr,
  input  logic [fsrm_pkg::APB_DW-1:0]      pwdata,
  output logic [fsrm_pkg::APB_DW-1:0]      prdata,
  output logic                             pready
);
  import fsrm_pkg::*;

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int MUL_W = IDX_W + STRIDE_W;

  cfg_t cfg;

  fsrm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Request register
  logic                act_vld_r;
  logic [ACTION_W-1:0] act_r;
  logic                peek_r;

  // Rotation state
  logic [IDX_W-1:0]     head_r,      head_nxt;
  logic [IDX_W-1:0]     tail_r,      tail_nxt;
  logic [IDX_W-1:0]     snap_r,      snap_nxt;
  logic                 resample_r,  resample_nxt;
  logic                 awaiting_r,  awaiting_nxt;
  logic [MAX_SLOTS-1:0] pending_r,   pending_nxt;

  // Result register
  logic                out_valid_r;
  logic                granted_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [OFFSET_W-1:0] offset_r;
  logic                clear_r;

  // Decision signals
  logic [31:0]      cnt_ext;
  logic [CNT_W-1:0] n_eff;
  logic [31:0]      n_ext;
  logic             single;
  logic             triple;
  logic [IDX_W-1:0] snap_eff;
  logic [IDX_W-1:0] head_nh;
  logic [IDX_W-1:0] tail_nt1;
  logic [IDX_W-1:0] tail_nt2;
  logic             grant;
  logic [IDX_W-1:0] sel;
  logic             clr;
  logic [MUL_W-1:0] prod;
  logic [63:0]      prod_ext;
  logic [31:0]      sel_ext;

  function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] i,
                                                  input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] inc;
    inc = CNT_W'(i) + CNT_W'(1);
    return (inc == n) ? '0 : IDX_W'(inc);
  endfunction

  // Clamp the slot count into 1..MAX_SLOTS.
  assign cnt_ext = {{(32-COUNT_W){1'b0}}, cfg.slot_count};
  always_comb begin
    if (cnt_ext == 32'd0) begin
      n_eff = CNT_W'(1);
    end else if (cnt_ext > 32'(MAX_SLOTS)) begin
      n_eff = CNT_W'(MAX_SLOTS);
    end else begin
      n_eff = CNT_W'(cnt_ext);
    end
  end

  assign n_ext    = 32'(n_eff);
  assign single   = (n_ext == 32'(SINGLE_COUNT));
  assign triple   = (n_ext == 32'(TRIPLE_COUNT));
  assign snap_eff = resample_r ? head_r : snap_r;
  assign head_nh  = wrap_next(head_r, n_eff);
  assign tail_nt1 = wrap_next(tail_r, n_eff);
  assign tail_nt2 = wrap_next(tail_nt1, n_eff);

  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    snap_nxt     = snap_r;
    resample_nxt = resample_r;
    awaiting_nxt = awaiting_r;
    pending_nxt  = pending_r;
    grant        = 1'b0;
    sel          = '0;
    clr          = 1'b0;
    if (act_vld_r) begin
      unique case (act_r)
        ACT_TAKE_HEAD: begin
          if (single) begin
            if (!awaiting_r) begin
              grant = 1'b1;
              sel   = head_nh;
            end
          end else if (head_r != tail_r) begin
            grant = 1'b1;
            sel   = triple ? tail_r : head_nh;
          end
          if (grant && !peek_r) begin
            head_nxt = sel;
          end
        end
        ACT_TAKE_TAIL: begin
          // Sample the reader's head once per writer turn.
          resample_nxt = 1'b0;
          snap_nxt     = snap_eff;
          if (single) begin
            if (!awaiting_r) begin
              resample_nxt = 1'b1;
            end else begin
              grant = 1'b1;
              sel   = tail_nt1;
            end
          end else if (triple) begin
            grant = 1'b1;
            sel   = (tail_nt1 == snap_eff) ? tail_nt2 : tail_nt1;
          end else if (tail_nt1 == snap_eff) begin
            resample_nxt = 1'b1;
          end else begin
            grant = 1'b1;
            sel   = tail_nt1;
          end
          if (grant) begin
            // Consume a pending header clear; a committed take re-arms it.
            clr              = pending_r[sel];
            pending_nxt[sel] = !peek_r;
            if (!peek_r) begin
              if (single) begin
                awaiting_nxt = 1'b0;
              end
              tail_nxt     = sel;
              resample_nxt = 1'b1;
            end
          end
        end
        ACT_RELEASE: begin
          if (single) begin
            awaiting_nxt = 1'b1;
          end
        end
        ACT_FLUSH: begin
          tail_nxt     = head_r;
          resample_nxt = 1'b1;
          snap_nxt     = '0;
        end
        ACT_RESET_SLOTS: begin
          pending_nxt  = '0;
          awaiting_nxt = 1'b0;
          tail_nxt     = head_r;
          resample_nxt = 1'b1;
          snap_nxt     = '0;
        end
        default: ;
      endcase
    end
    if (cfg.rebuild) begin
      head_nxt     = '0;
      tail_nxt     = '0;
      snap_nxt     = '0;
      resample_nxt = 1'b1;
      awaiting_nxt = 1'b0;
      pending_nxt  = '0;
    end
  end

  assign sel_ext  = 32'(sel);
  assign prod     = MUL_W'(sel) * MUL_W'(cfg.slot_stride);
  assign prod_ext = 64'(prod);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_vld_r   <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      snap_r      <= '0;
      resample_r  <= 1'b1;
      awaiting_r  <= 1'b0;
      pending_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      act_vld_r   <= start & !busy;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      snap_r      <= snap_nxt;
      resample_r  <= resample_nxt;
      awaiting_r  <= awaiting_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= act_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start & !busy) begin
      act_r  <= in_action;
      peek_r <= in_peek;
    end
    if (act_vld_r) begin
      granted_r <= grant;
      slot_r    <= grant ? sel_ext[SLOT_W-1:0] : '0;
      offset_r  <= grant ? prod_ext[OFFSET_W-1:0] : '0;
      clear_r   <= grant & clr;
    end
  end

  assign busy             = 1'b0;
  assign out_valid        = out_valid_r;
  assign out_granted      = granted_r;
  assign out_slot         = slot_r;
  assign out_slot_offset  = offset_r;
  assign out_clear_header = clear_r;

  `FSRM_ASSERT_NXT(a_request_yields_result, act_vld_r, out_valid_r, "request lost in pipeline")
  `FSRM_ASSERT_IMP(a_indices_in_range, 1'b1, (CNT_W'(head_r) < n_eff) && (CNT_W'(tail_r) < n_eff), "head or tail beyond slot count")
  `FSRM_ASSERT_IMP(a_triple_skips_reader, act_vld_r && (act_r == ACT_TAKE_TAIL) && triple && grant, sel != snap_eff, "writer granted the reader slot")
  `FSRM_ASSERT_IMP(a_denied_is_zero, out_valid && !out_granted, (out_slot == '0) && (out_slot_offset == '0) && !out_clear_header, "denied result carries data")

endmodule

// File: design/fsrm_regs.sv
// APB configuration registers: slot count and slot stride.
// Depends on fsrm_pkg; feeds cfg_t to the top level.
module fsrm_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fsrm_pkg::APB_AW-1:0]  paddr,
  input  logic [fsrm_pkg::APB_DW-1:0]  pwdata,
  output logic [fsrm_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output fsrm_pkg::cfg_t               cfg
);
  import fsrm_pkg::*;

  logic [COUNT_W-1:0]  slot_count_r;
  logic [STRIDE_W-1:0] slot_stride_r;
  logic                wr_en;
  logic                reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r  <= COUNT_RST;
      slot_stride_r <= STRIDE_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_SLOT_COUNT:  slot_count_r  <= pwdata[COUNT_W-1:0];
        REG_SLOT_STRIDE: slot_stride_r <= pwdata[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SLOT_COUNT:  prdata = {{(APB_DW-COUNT_W){1'b0}}, slot_count_r};
      REG_SLOT_STRIDE: prdata = {{(APB_DW-STRIDE_W){1'b0}}, slot_stride_r};
      default:         prdata = '0;
    endcase
  end

  assign cfg.slot_count  = slot_count_r;
  assign cfg.slot_stride = slot_stride_r;
  assign cfg.rebuild     = wr_en & (reg_sel == REG_SLOT_COUNT);

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for frame_slot_rotation_manager: drives slot requests
// and APB register writes, predicts every result in a scoreboard class.
// Depends on fsrm_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module testbench;
  import fsrm_pkg::*;

  localparam int STALL_LIMIT = 500;
  localparam int NUM_SLOTS   = 8;

  typedef struct {
    bit                granted;
    bit [SLOT_W-1:0]   slot;
    bit [OFFSET_W-1:0] offset;
    bit                clear;
  } slot_grant_t;

  class slot_scoreboard;
    bit [COUNT_W-1:0]  count;
    bit [STRIDE_W-1:0] stride;
    bit [SLOT_W-1:0]   head, tail, snap;
    bit                resample, awaiting;
    bit                hdr_pending[NUM_SLOTS];
    slot_grant_t       grants_due[$];
    int                errors, requests, grants, clears;

    function new();
      count    = COUNT_RST;
      stride   = STRIDE_RST;
      head     = '0;
      clear_slots();
    endfunction

    function void flush_tail();
      tail     = head;
      resample = 1'b1;
      snap     = '0;
    endfunction

    function void clear_slots();
      foreach (hdr_pending[i]) hdr_pending[i] = 1'b0;
      awaiting = 1'b0;
      flush_tail();
    endfunction

    function void write_reg(logic idx, logic [APB_DW-1:0] value);
      if (idx == REG_SLOT_COUNT) begin
        count = value[COUNT_W-1:0];
        head  = '0;
        clear_slots();
      end else begin
        stride = value[STRIDE_W-1:0];
      end
    endfunction

    function void check_readback(logic idx, logic [APB_DW-1:0] value);
      logic [APB_DW-1:0] want;
      want = (idx == REG_SLOT_COUNT) ? APB_DW'(count) : APB_DW'(stride);
      if (value !== want) begin
        $display("%0t: register %0d readback, expected %0h, actual %0h",
                 $time, idx, want, value);
        errors++;
      end
    endfunction

    function void note_request(logic [ACTION_W-1:0] act, logic peek);
      int n, nh, nt;
      bit ok, clr;
      slot_grant_t res;
      n   = (count == 0) ? 1 : (count > NUM_SLOTS) ? NUM_SLOTS : int'(count);
      head = SLOT_W'(int'(head) % n);
      tail = SLOT_W'(int'(tail) % n);
      snap = SLOT_W'(int'(snap) % n);
      ok  = 1'b0;
      clr = 1'b0;
      nt  = 0;
      case (action_t'(act))
        ACT_TAKE_HEAD: begin
          nh = (int'(head) + 1) % n;
          if (n == SINGLE_COUNT) begin
            ok = !awaiting;
          end else begin
            ok = (head != tail);
            if (n == TRIPLE_COUNT) nh = tail;
          end
          if (ok && !peek) head = SLOT_W'(nh);
          nt = nh;
        end
        ACT_TAKE_TAIL: begin
          // sample the reader position once per writer turn, even on peek
          if (resample) begin
            resample = 1'b0;
            snap     = head;
          end
          nt = (int'(tail) + 1) % n;
          ok = 1'b1;
          if (n == SINGLE_COUNT) begin
            if (!awaiting) begin
              resample = 1'b1;
              ok       = 1'b0;
            end
          end else if (n == TRIPLE_COUNT) begin
            if (nt == snap) nt = (nt + 1) % n;
          end else if (nt == snap) begin
            resample = 1'b1;
            ok       = 1'b0;
          end
          if (ok) begin
            nt  = nt % NUM_SLOTS;
            clr = hdr_pending[nt];
            hdr_pending[nt] = 1'b0;
            if (!peek) begin
              hdr_pending[nt] = 1'b1;
              if (n == SINGLE_COUNT) awaiting = 1'b0;
              tail     = SLOT_W'(nt);
              resample = 1'b1;
            end
          end
        end
        ACT_RELEASE:     if (n == SINGLE_COUNT) awaiting = 1'b1;
        ACT_FLUSH:       flush_tail();
        ACT_RESET_SLOTS: clear_slots();
        default: ;
      endcase
      res.granted = ok;
      res.slot    = ok ? SLOT_W'(nt) : '0;
      res.offset  = ok ? OFFSET_W'(nt * int'(stride)) : '0;
      res.clear   = ok && clr;
      grants_due.push_back(res);
      requests++;
      if (ok) grants++;
      if (res.clear) clears++;
    endfunction

    function void compare_field(string name, logic [OFFSET_W-1:0] want,
                                logic [OFFSET_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic granted, logic [SLOT_W-1:0] slot,
                               logic [OFFSET_W-1:0] offset, logic clear);
      slot_grant_t want;
      if (grants_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual granted=%0b slot=%0d",
                 $time, granted, slot);
        errors++;
        return;
      end
      want = grants_due.pop_front();
      compare_field("granted", OFFSET_W'(want.granted), OFFSET_W'(granted));
      compare_field("slot", OFFSET_W'(want.slot), OFFSET_W'(slot));
      compare_field("slot_offset", want.offset, offset);
      compare_field("clear_header", OFFSET_W'(want.clear), OFFSET_W'(clear));
    endfunction

    function int pending_count();
      return grants_due.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [ACTION_W-1:0] in_action;
  logic                in_peek;
  logic                out_valid;
  logic                out_granted;
  logic [SLOT_W-1:0]   out_slot;
  logic [OFFSET_W-1:0] out_slot_offset;
  logic                out_clear_header;
  logic                psel, penable, pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  slot_scoreboard sb;
  bit             no_idle;
  int             settings;
  int             stall_cycles;

  frame_slot_rotation_manager u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_peek          (in_peek),
    .out_valid        (out_valid),
    .out_granted      (out_granted),
    .out_slot         (out_slot),
    .out_slot_offset  (out_slot_offset),
    .out_clear_header (out_clear_header),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_request(in_action, in_peek);
      if (out_valid) sb.check_result(out_granted, out_slot, out_slot_offset, out_clear_header);
      if (psel && penable && pready) begin
        if (pwrite) sb.write_reg(paddr[2], pwdata);
        else sb.check_readback(paddr[2], prdata);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send(input logic [ACTION_W-1:0] act, input bit pk);
    int gap;
    bit was_busy;
    if (!no_idle && $urandom_range(0, 99) < 14) begin
      gap       = $urandom_range(1, 3);
      start     = 1'b0;
      in_action = ACTION_W'($urandom);
      in_peek   = 1'($urandom);
      repeat (gap) @(negedge clk);
    end
    start     = 1'b1;
    in_action = act;
    in_peek   = pk;
    forever begin
      was_busy = busy;
      @(negedge clk);
      if (!was_busy) break;
    end
  endtask

  task automatic drain();
    start = 1'b0;
    while (sb.pending_count() != 0) @(negedge clk);
  endtask

  task automatic cfg_access(input bit wr, input logic idx, input logic [APB_DW-1:0] value);
    psel    = 1'b1;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    while (!pready) @(negedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_mode(input logic [COUNT_W-1:0] cnt, input logic [STRIDE_W-1:0] str);
    drain();
    cfg_access(1'b1, REG_SLOT_STRIDE, APB_DW'(str));
    cfg_access(1'b1, REG_SLOT_COUNT, APB_DW'(cnt));
    cfg_access(1'b0, REG_SLOT_COUNT, '0);
    cfg_access(1'b0, REG_SLOT_STRIDE, '0);
    settings++;
  endtask

  initial begin
    int counts[12];
    int r, tail_pct;
    logic [STRIDE_W-1:0] str;
    logic [ACTION_W-1:0] act;
    counts    = '{2, 4, 1, 8, 0, 15, 3, 5, 6, 7, 1, 3};
    sb        = new();
    rst_n     = 1'b0;
    start     = 1'b0;
    in_action = '0;
    in_peek   = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset values, then single-slot handoff
    cfg_access(1'b0, REG_SLOT_COUNT, '0);
    cfg_access(1'b0, REG_SLOT_STRIDE, '0);
    send(ACT_TAKE_HEAD, 1'b0);
    send(ACT_TAKE_TAIL, 1'b0);
    send(ACT_RELEASE, 1'b0);
    send(ACT_TAKE_TAIL, 1'b1);
    send(ACT_TAKE_TAIL, 1'b0);
    send(ACT_RELEASE, 1'b1);
    send(ACT_TAKE_TAIL, 1'b0);
    send(ACT_TAKE_HEAD, 1'b0);
    send(3'd7, 1'b1);
    send(3'd5, 1'b0);
    send(3'd6, 1'b0);
    send(ACT_FLUSH, 1'b1);
    send(ACT_RESET_SLOTS, 1'b1);

    // triple rotation with the widest stride: skip over the reader's slot
    set_mode(COUNT_W'(TRIPLE_COUNT), 19'h7FFFF);
    send(ACT_TAKE_HEAD, 1'b0);
    send(ACT_TAKE_TAIL, 1'b1);
    send(ACT_TAKE_TAIL, 1'b0);
    send(ACT_TAKE_TAIL, 1'b0);
    send(ACT_TAKE_TAIL, 1'b0);
    send(ACT_TAKE_HEAD, 1'b1);
    send(ACT_TAKE_HEAD, 1'b0);
    send(ACT_TAKE_HEAD, 1'b0);

    set_mode(4'd8, 19'd32);
    send(ACT_TAKE_TAIL, 1'b0);
    send(ACT_TAKE_HEAD, 1'b0);
    send(ACT_TAKE_TAIL, 1'b1);

    for (int p = 0; p < 12; p++) begin
      case (p)
        0:       str = 19'h7FFFF;
        1:       str = '0;
        2:       str = STRIDE_RST;
        3:       str = 19'd32;
        default: str = STRIDE_W'($urandom);
      endcase
      set_mode(COUNT_W'(counts[p]), str);
      tail_pct = $urandom_range(35, 65);
      no_idle  = (p == 4);
      for (int k = 0; k < 86; k++) begin
        r = $urandom_range(0, 99);
        if (r < 3)       act = ACTION_W'($urandom_range(5, 7));
        else if (r < 6)  act = ACT_RESET_SLOTS;
        else if (r < 12) act = ACT_FLUSH;
        else if (r < 24) act = ACT_RELEASE;
        else if ($urandom_range(0, 99) < tail_pct) act = ACT_TAKE_TAIL;
        else act = ACT_TAKE_HEAD;
        send(act, $urandom_range(0, 99) < 20);
      end
    end
    no_idle = 1'b0;

    drain();
    repeat (4) @(negedge clk);
    $display("Run covered %0d requests over %0d register settings", sb.requests, settings);
    $display("  with %0d slots granted and %0d header clears", sb.grants, sb.clears);
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/fsrm_pkg.sv
design/fsrm_regs.sv
design/frame_slot_rotation_manager.sv
tb/sv/testbench.sv
